[sv/tosat_pkg.sv]
package tosat_pkg;

	// Default coordinate width of one vertex component.
	localparam int COORD_WIDTH_DEF = 16;

	// A triangle has three vertices and gives three candidate axes.
	localparam int NUM_VERT = 3;

	// Six candidate axes in all, three from each triangle.
	localparam int NUM_AXES = 2 * NUM_VERT;

endpackage

[sv/tosat_if.sv]
// Word carrying one pair of triangles.
interface tosat_pair_if
	import tosat_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] a_x0;
	logic signed [COORD_WIDTH-1:0] a_y0;
	logic signed [COORD_WIDTH-1:0] a_x1;
	logic signed [COORD_WIDTH-1:0] a_y1;
	logic signed [COORD_WIDTH-1:0] a_x2;
	logic signed [COORD_WIDTH-1:0] a_y2;
	logic signed [COORD_WIDTH-1:0] b_x0;
	logic signed [COORD_WIDTH-1:0] b_y0;
	logic signed [COORD_WIDTH-1:0] b_x1;
	logic signed [COORD_WIDTH-1:0] b_y1;
	logic signed [COORD_WIDTH-1:0] b_x2;
	logic signed [COORD_WIDTH-1:0] b_y2;

	modport source (
		output valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
		output b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
		input  ready
	);

	modport sink (
		input  valid, a_x0, a_y0, a_x1, a_y1, a_x2, a_y2,
		input  b_x0, b_y0, b_x1, b_y1, b_x2, b_y2,
		output ready
	);
endinterface

// Word carrying one overlap verdict.
interface tosat_res_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (
		output valid, overlap,
		input  ready
	);

	modport sink (
		input  valid, overlap,
		output ready
	);
endinterface

[sv/triangle_overlap_sat_2d.sv]
// Path: a word taken at a clock edge goes into the input register, then into
// the projection register, then into the result register, where its verdict
// is shown until it is taken.
// Throughput: one triangle pair per cycle while the output is taken; a verdict
// waiting on the output stalls every stage and holds the input ready low.
// Reset: arst_n clears the valid flags of all stages; data registers keep junk.
module triangle_overlap_sat_2d
	import tosat_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	tosat_pair_if.sink          pair,
	tosat_res_if.source         result
);

	// The pipeline has three stages that move together. Stage one holds the
	// vertices, stage two holds the 36 projections (inside the axis units),
	// and the result register holds the verdict. The whole pipeline advances
	// whenever the result register is empty or is being taken, so a stall on
	// the output holds every stage in place and nothing is lost or repeated.

	logic                          adv;
	logic                          v_s1;
	logic                          v_s2;
	logic                          res_v_q;
	logic                          overlap_q;
	logic signed [COORD_WIDTH-1:0] ax_s1 [NUM_VERT];
	logic signed [COORD_WIDTH-1:0] ay_s1 [NUM_VERT];
	logic signed [COORD_WIDTH-1:0] bx_s1 [NUM_VERT];
	logic signed [COORD_WIDTH-1:0] by_s1 [NUM_VERT];
	logic [NUM_AXES-1:0]           sep;

	assign adv         = !res_v_q || result.ready;
	assign pair.ready  = adv;

	// Input register.
	always_ff @(posedge clk) begin
		if (adv && pair.valid) begin
			ax_s1[0] <= pair.a_x0;
			ay_s1[0] <= pair.a_y0;
			ax_s1[1] <= pair.a_x1;
			ay_s1[1] <= pair.a_y1;
			ax_s1[2] <= pair.a_x2;
			ay_s1[2] <= pair.a_y2;
			bx_s1[0] <= pair.b_x0;
			by_s1[0] <= pair.b_y0;
			bx_s1[1] <= pair.b_x1;
			by_s1[1] <= pair.b_y1;
			bx_s1[2] <= pair.b_x2;
			by_s1[2] <= pair.b_y2;
		end
	end

	// Six axis units, one per edge. Axes zero to two come from triangle A,
	// three to five from triangle B; edge i runs from vertex i to the next
	// vertex, wrapping from the last back to the first.
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
		localparam int I = k % NUM_VERT;
		localparam int J = (I + 1) % NUM_VERT;

		if (k < NUM_VERT) begin : g_a
			tosat_axis #(
				.COORD_WIDTH(COORD_WIDTH)
			) u_axis (
				.clk (clk),
				.en  (adv && v_s1),
				.e0_x(ax_s1[I]),
				.e0_y(ay_s1[I]),
				.e1_x(ax_s1[J]),
				.e1_y(ay_s1[J]),
				.ax  (ax_s1),
				.ay  (ay_s1),
				.bx  (bx_s1),
				.by  (by_s1),
				.sep (sep[k])
			);
		end else begin : g_b
			tosat_axis #(
				.COORD_WIDTH(COORD_WIDTH)
			) u_axis (
				.clk (clk),
				.en  (adv && v_s1),
				.e0_x(bx_s1[I]),
				.e0_y(by_s1[I]),
				.e1_x(bx_s1[J]),
				.e1_y(by_s1[J]),
				.ax  (ax_s1),
				.ay  (ay_s1),
				.bx  (bx_s1),
				.by  (by_s1),
				.sep (sep[k])
			);
		end
	end

	// Result register: the pair overlaps when no axis separates it.
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			overlap_q <= ~|sep;
		end
	end

	// Valid flags of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			res_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= pair.valid;
			v_s2    <= v_s1;
			res_v_q <= v_s2;
		end
	end

	assign result.valid   = res_v_q;
	assign result.overlap = overlap_q;

`ifndef SYNTH
	// An accepted word always occupies the input stage on the next cycle.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pair.valid && pair.ready |=> v_s1)
		else $error("accepted word did not reach the input stage");

	// While the output is stalled, every occupied stage keeps its word.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> v_s1 == $past(v_s1) && v_s2 == $past(v_s2)
			&& result.valid)
		else $error("pipeline moved during an output stall");

	// A result appears only from a word that was in the projection stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(v_s2))
		else $error("result shown without a word behind it");

	// A stalled verdict does not change.
	a_verdict_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(overlap_q))
		else $error("verdict changed while waiting");
`endif

endmodule

[sv/tosat_axis.sv]
// One candidate axis: projects all six vertices on the edge normal, registers
// the projections, then compares the two extents.
module tosat_axis
	import tosat_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] e0_x,
	input  logic signed [COORD_WIDTH-1:0] e0_y,
	input  logic signed [COORD_WIDTH-1:0] e1_x,
	input  logic signed [COORD_WIDTH-1:0] e1_y,
	input  logic signed [COORD_WIDTH-1:0] ax [NUM_VERT],
	input  logic signed [COORD_WIDTH-1:0] ay [NUM_VERT],
	input  logic signed [COORD_WIDTH-1:0] bx [NUM_VERT],
	input  logic signed [COORD_WIDTH-1:0] by [NUM_VERT],
	output logic                          sep
);

	localparam int EW = COORD_WIDTH + 1;
	localparam int DW = 2 * COORD_WIDTH + 2;

	logic signed [EW-1:0] nx;
	logic signed [EW-1:0] ny;
	logic signed [DW-1:0] da [NUM_VERT];
	logic signed [DW-1:0] db [NUM_VERT];
	logic signed [DW-1:0] da_s2 [NUM_VERT];
	logic signed [DW-1:0] db_s2 [NUM_VERT];
	logic signed [DW-1:0] amin, amax, bmin, bmax;

	// Normal is the edge rotated by a quarter turn: (-ey, ex).
	assign nx = EW'(e0_y) - EW'(e1_y);
	assign ny = EW'(e1_x) - EW'(e0_x);

	// Exact dot products; DW bits hold any product sum without overflow.
	always_comb begin
		for (int v = 0; v < NUM_VERT; v++) begin
			da[v] = DW'(ax[v]) * DW'(nx) + DW'(ay[v]) * DW'(ny);
			db[v] = DW'(bx[v]) * DW'(nx) + DW'(by[v]) * DW'(ny);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			da_s2 <= da;
			db_s2 <= db;
		end
	end

	always_comb begin
		amin = da_s2[0];
		amax = da_s2[0];
		bmin = db_s2[0];
		bmax = db_s2[0];
		for (int v = 1; v < NUM_VERT; v++) begin
			if (da_s2[v] < amin) amin = da_s2[v];
			if (da_s2[v] > amax) amax = da_s2[v];
			if (db_s2[v] < bmin) bmin = db_s2[v];
			if (db_s2[v] > bmax) bmax = db_s2[v];
		end
		// Touching extremes do not separate.
		sep = (amax < bmin) || (bmax < amin);
	end

endmodule

[bench/testbench.sv]
// Self-checking bench for triangle_overlap_sat_2d.
module testbench;
	import tosat_pkg::*;

	localparam int COORD_WIDTH = COORD_WIDTH_DEF;

	// The watchdog fires after this many cycles without a single handshake on
	// either channel. The slowest phase stalls in 85 percent of its cycles, so even
	// long random stretches stay far below it.
	localparam int WATCHDOG_LIMIT = 2000;

	// The block answers after its word passes the input, projection and result
	// registers; spare cycles after the last result catch anything late or unasked.
	localparam int DRAIN_CYCLES = 8;

	// Random words per idling phase; four phases plus the directed words make
	// up the whole run.
	localparam int WORDS_PER_PHASE = 385;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// A projection needs 2*COORD_WIDTH+2 bits; this leaves ample headroom.
	typedef logic signed [2*COORD_WIDTH+15:0] proj_t;

	// One pair word: vertex k of triangle A is (ax[k], ay[k]), same for B.
	typedef struct {
		coord_t ax[3];
		coord_t ay[3];
		coord_t bx[3];
		coord_t by[3];
	} tri_pair_t;

	// Keeps the verdicts that are owed by the block, in the order in which
	// their pair words were taken, and compares each returned verdict.
	class overlap_scoreboard;
		bit verdicts[$];
		int errors;

		// Separating axis test with exact wide arithmetic. Each edge of the two
		// triangles gives the axis (-ey, ex); a zero-length edge gives a null axis
		// on which every projection is zero, so it can never separate.
		// Equal extremes count as touching.
		function bit predict_overlap(tri_pair_t p);
			proj_t vx[6];
			proj_t vy[6];
			proj_t nx, ny, pr;
			proj_t amin, amax, bmin, bmax;
			int base;
			bit hit;
			hit = 1'b1;
			for (int k = 0; k < 3; k++) begin
				vx[k]     = p.ax[k];
				vy[k]     = p.ay[k];
				vx[k + 3] = p.bx[k];
				vy[k + 3] = p.by[k];
			end
			for (int t = 0; t < 2; t++) begin
				base = 3 * t;
				for (int i = 0; i < 3; i++) begin
					nx = vy[base + i] - vy[base + (i + 1) % 3];
					ny = vx[base + (i + 1) % 3] - vx[base + i];
					amin = vx[0] * nx + vy[0] * ny;
					amax = amin;
					bmin = vx[3] * nx + vy[3] * ny;
					bmax = bmin;
					for (int v = 1; v < 3; v++) begin
						pr = vx[v] * nx + vy[v] * ny;
						if (pr < amin) amin = pr;
						if (pr > amax) amax = pr;
						pr = vx[v + 3] * nx + vy[v + 3] * ny;
						if (pr < bmin) bmin = pr;
						if (pr > bmax) bmax = pr;
					end
					if (amax < bmin || bmax < amin)
						hit = 1'b0;
				end
			end
			return hit;
		endfunction

		function void note_pair(tri_pair_t p);
			verdicts.push_back(predict_overlap(p));
		endfunction

		function void check_verdict(logic got);
			bit want;
			if (verdicts.size() == 0) begin
				$display("%0t: verdict %b arrived with none outstanding", $time, got);
				errors++;
			end else begin
				want = verdicts.pop_front();
				if (got !== want) begin
					$display("%0t: overlap expected %b, got %b", $time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tosat_pair_if #(.COORD_WIDTH(COORD_WIDTH)) pair ();
	tosat_res_if result ();

	triangle_overlap_sat_2d #(
		.COORD_WIDTH(COORD_WIDTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair.sink),
		.result (result.source)
	);

	overlap_scoreboard sb = new;

	// Chance, in percent, that the sender skips a cycle and that the receiver
	// holds off for a cycle. Each phase of the run sets both.
	int sender_idle_pct;
	int receiver_stall_pct;
	int idle_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver decides at each falling edge whether it takes a verdict at
	// the next rising edge. Exactly one assignment per falling edge.
	always @(negedge clk) begin
		result.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Both channels are watched at the rising edge, where the block itself
	// samples them. Every input changes at the falling edge only, and the
	// block's outputs change after this process has read them, so the
	// sampled values do not depend on the order of processes within the edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if (pair.valid && pair.ready) begin
				tri_pair_t seen;
				seen.ax[0] = pair.a_x0;
				seen.ay[0] = pair.a_y0;
				seen.ax[1] = pair.a_x1;
				seen.ay[1] = pair.a_y1;
				seen.ax[2] = pair.a_x2;
				seen.ay[2] = pair.a_y2;
				seen.bx[0] = pair.b_x0;
				seen.by[0] = pair.b_y0;
				seen.bx[1] = pair.b_x1;
				seen.by[1] = pair.b_y1;
				seen.bx[2] = pair.b_x2;
				seen.by[2] = pair.b_y2;
				sb.note_pair(seen);
			end
			if (result.valid && result.ready)
				sb.check_verdict(result.overlap);
			if ((pair.valid && pair.ready) || (result.valid && result.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Builds a pair word from twelve integers in port order:
	// a_x0, a_y0, a_x1, a_y1, a_x2, a_y2, then the same for B.
	function automatic tri_pair_t make_pair(int c[12]);
		tri_pair_t p;
		for (int k = 0; k < 3; k++) begin
			p.ax[k] = coord_t'(c[2 * k]);
			p.ay[k] = coord_t'(c[2 * k + 1]);
			p.bx[k] = coord_t'(c[6 + 2 * k]);
			p.by[k] = coord_t'(c[7 + 2 * k]);
		end
		return p;
	endfunction

	// Random pair words. Two in five are two small triangles placed near each
	// other so that both verdicts are common; others are built to touch exactly
	// at a vertex or along an edge, or to miss that contact by one unit, and the
	// rest cover degenerate shapes, full-range coordinates and extremes.
	function automatic tri_pair_t random_pair();
		int c[12];
		int pick, cx, cy, r, ox, oy, k, m, dx, dy, src, dst, base;
		pick = $urandom_range(99);
		cx = int'($urandom_range(16000)) - 8000;
		cy = int'($urandom_range(16000)) - 8000;
		r  = int'($urandom_range(1 << $urandom_range(12)));
		ox = int'($urandom_range(4 * r)) - 2 * r;
		oy = int'($urandom_range(4 * r)) - 2 * r;
		for (int n = 0; n < 3; n++) begin
			c[2 * n]     = cx + int'($urandom_range(2 * r)) - r;
			c[2 * n + 1] = cy + int'($urandom_range(2 * r)) - r;
			c[6 + 2 * n] = cx + ox + int'($urandom_range(2 * r)) - r;
			c[7 + 2 * n] = cy + oy + int'($urandom_range(2 * r)) - r;
		end
		if (pick < 10) begin
			// Full-range coordinates: every bit of every field toggles.
			for (int n = 0; n < 12; n++)
				c[n] = int'($urandom_range(65535)) - 32768;
		end else if (pick < 50) begin
			// Two nearby clusters, as generated above.
		end else if (pick < 70) begin
			// B is A mirrored through one of A's vertices, so the two touch at
			// that single point; in each axis, half the time, B is nudged by up to one unit.
			k  = $urandom_range(2);
			dx = $urandom_range(1) ? int'($urandom_range(2)) - 1 : 0;
			dy = $urandom_range(1) ? int'($urandom_range(2)) - 1 : 0;
			for (int n = 0; n < 3; n++) begin
				c[6 + 2 * n] = 2 * c[2 * k] - c[2 * n] + dx;
				c[7 + 2 * n] = 2 * c[2 * k + 1] - c[2 * n + 1] + dy;
			end
		end else if (pick < 82) begin
			// B takes over one or two of A's vertices: shared corner or edge.
			for (int s = 0; s <= int'($urandom_range(1)); s++) begin
				src = $urandom_range(2);
				dst = $urandom_range(2);
				c[6 + 2 * dst] = c[2 * src];
				c[7 + 2 * dst] = c[2 * src + 1];
			end
		end else if (pick < 90) begin
			// One triangle collapses to a segment or repeats a vertex.
			base = 6 * int'($urandom_range(1));
			m = int'($urandom_range(4)) - 2;
			c[base + 4] = c[base] + m * (c[base + 2] - c[base]);
			c[base + 5] = c[base + 1] + m * (c[base + 3] - c[base + 1]);
		end else begin
			for (int n = 0; n < 12; n++) begin
				case ($urandom_range(5))
					0: c[n] = -32768;
					1: c[n] = 32767;
					2: c[n] = 0;
					3: c[n] = -1;
					4: c[n] = 1;
					default: c[n] = int'($urandom_range(65535)) - 32768;
				endcase
			end
		end
		return make_pair(c);
	endfunction

	// Offers one pair word, idling first as the current phase asks, and holds
	// it until the block takes it. Called and returning at a falling edge.
	task automatic send_pair(tri_pair_t p);
		while ($urandom_range(99) < sender_idle_pct) begin
			pair.valid <= 1'b0;
			@(negedge clk);
		end
		pair.valid <= 1'b1;
		pair.a_x0  <= p.ax[0];
		pair.a_y0  <= p.ay[0];
		pair.a_x1  <= p.ax[1];
		pair.a_y1  <= p.ay[1];
		pair.a_x2  <= p.ax[2];
		pair.a_y2  <= p.ay[2];
		pair.b_x0  <= p.bx[0];
		pair.b_y0  <= p.by[0];
		pair.b_x1  <= p.bx[1];
		pair.b_y1  <= p.by[1];
		pair.b_x2  <= p.bx[2];
		pair.b_y2  <= p.by[2];
		@(posedge clk);
		while (!pair.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hand-picked pairs: extremes, touching and just-missing contacts, null
	// axes and flat triangles.
	task automatic send_directed();
		// All vertices at the origin: every axis is null, so they overlap.
		send_pair(make_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
		send_pair(make_pair('{32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767, 32767, 32767}));
		send_pair(make_pair('{-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, -32768, -32768}));
		// Two points at opposite corners: no edge has length, so no axis can
		// part them and the verdict is overlap.
		send_pair(make_pair('{-32768, -32768, -32768, -32768, -32768, -32768,
			32767, 32767, 32767, 32767, 32767, 32767}));
		// Largest triangle against a sliver in the far corner: the long
		// hypotenuse parts them.
		send_pair(make_pair('{-32768, -32768, 32767, -32768, -32768, 32767,
			32767, 32767, 32767, 32766, 32766, 32767}));
		// Small triangle around the origin, crossing the hypotenuse of the largest one.
		send_pair(make_pair('{-32768, -32768, 32767, -32768, -32768, 32767,
			-1, -1, 1, 0, 0, 1}));
		// And the same the other way round.
		send_pair(make_pair('{-1, -1, 1, 0, 0, 1,
			-32768, -32768, 32767, -32768, -32768, 32767}));
		// Touching at one vertex, then one unit apart.
		send_pair(make_pair('{0, 0, 10, 0, 0, 10, 20, 0, 10, 0, 20, -10}));
		send_pair(make_pair('{0, 0, 10, 0, 0, 10, 21, 0, 11, 0, 21, -10}));
		// Sharing a whole edge, then moved off it.
		send_pair(make_pair('{0, 0, 10, 0, 0, 10, 10, 0, 0, 10, 10, 10}));
		send_pair(make_pair('{0, 0, 10, 0, 0, 10, 11, 1, 1, 11, 11, 11}));
		// Repeated vertex in A (a null axis) with the segment through B.
		send_pair(make_pair('{5, 5, 5, 5, 20, 5, 10, 0, 12, 10, 8, 10}));
		// Flat A along the diagonal with B wholly below it.
		send_pair(make_pair('{-100, -100, 0, 0, 100, 100, 50, -50, 60, -40, 70, -60}));
		// Plainly apart, axis from B's slanted edge.
		send_pair(make_pair('{0, 0, 10, 0, 0, 10, 6, 6, 20, 6, 6, 20}));
		// Alternating bit patterns.
		send_pair(make_pair('{21845, -21846, -21846, 21845, 21845, 21845,
			-21846, -21846, 21845, -21846, -21846, 21845}));
		// Full-range triangles that cross.
		send_pair(make_pair('{-32768, 0, 32767, 0, 0, 32767,
			-32768, 32767, 32767, 32767, 0, -32768}));
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		idle_cycles        = 0;
		pair.valid         = 1'b0;
		pair.a_x0          = '0;
		pair.a_y0          = '0;
		pair.a_x1          = '0;
		pair.a_y1          = '0;
		pair.a_x2          = '0;
		pair.a_y2          = '0;
		pair.b_x0          = '0;
		pair.b_y0          = '0;
		pair.b_x1          = '0;
		pair.b_y1          = '0;
		pair.b_x2          = '0;
		pair.b_y2          = '0;
		result.ready       = 1'b0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		send_directed();

		// Four idling phases: free flow, a sparse sender, a slow receiver,
		// and both at once.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct    = 85;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 85;
				end
				default: begin
					sender_idle_pct    = 38;
					receiver_stall_pct = 38;
				end
			endcase
			repeat (WORDS_PER_PHASE)
				send_pair(random_pair());
		end
		pair.valid <= 1'b0;

		// Drain: the watchdog bounds this wait if verdicts stop coming.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
